FILE: rtl/core/mbcb_pkg.sv
// Shared types, codes and constants of the masked blend convolution blur.
package mbcb_pkg;

  localparam int TEX_DIM_DEF  = 64;
  localparam int MAX_TAPS_DEF = 8;

  localparam int POS_W      = 12;
  localparam int CHAN_W     = 16;
  localparam int NUM_CHAN   = 4;
  localparam int PIX_W      = CHAN_W * NUM_CHAN;
  localparam int WS_W       = 23;
  localparam int BF_W       = 17;
  localparam int FULL_BLEND = 65536;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [NUM_CHAN-1:0] ALL_CHANNELS = 4'hf;

  // input command codes
  localparam logic [1:0] CMD_LOAD_PIX  = 2'd0;
  localparam logic [1:0] CMD_LOAD_COEF = 2'd1;
  localparam logic [1:0] CMD_COMPUTE   = 2'd2;

  // filter modes
  localparam logic [1:0] MODE_2D    = 2'd0;
  localparam logic [1:0] MODE_HORIZ = 2'd1;
  localparam logic [1:0] MODE_VERT  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] REG_FILTER_WIDTH  = 3'd1;
  localparam logic [2:0] REG_FILTER_HEIGHT = 3'd2;
  localparam logic [2:0] REG_WEIGHT_SUM    = 3'd3;
  localparam logic [2:0] REG_BLEND_FACTOR  = 3'd4;
  localparam logic [2:0] REG_CHANNEL_MASK  = 3'd5;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd7;

  typedef struct packed {
    logic [1:0]               command;
    logic [POS_W-1:0]         position;
    logic signed [CHAN_W-1:0] chan0;
    logic signed [CHAN_W-1:0] chan1;
    logic signed [CHAN_W-1:0] chan2;
    logic signed [CHAN_W-1:0] chan3;
    logic signed [CHAN_W-1:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         pixel_index;
    logic signed [CHAN_W-1:0] out_chan0;
    logic signed [CHAN_W-1:0] out_chan1;
    logic signed [CHAN_W-1:0] out_chan2;
    logic signed [CHAN_W-1:0] out_chan3;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          filter_mode;
    logic [3:0]          filter_width;
    logic [3:0]          filter_height;
    logic [WS_W-1:0]     weight_sum;
    logic [BF_W-1:0]     blend_factor;
    logic [NUM_CHAN-1:0] channel_mask;
    logic [6:0]          image_width;
    logic [6:0]          image_height;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_XMID, S_DIVY, S_YMID, S_CENTER, S_OFFS,
    S_TAPS, S_DRAIN, S_DIV, S_BLEND, S_FIN, S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    XY_HOLD, XY_STEP, XY_LOAD_Y, XY_FINISH
  } xy_op_t;

  typedef struct packed {
    logic   take;
    logic   wr_tex;
    logic   wr_coef;
    xy_op_t xy_op;
    logic   back_step;
    logic   issue_center;
    logic   issue_tap;
    logic   div_load;
    logic   div_step;
    logic   blend_mul;
    logic   blend_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic offs_done;
    logic last_tap;
    logic pipe_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/masked_blend_convolution_blur.sv
// Top level of the masked blend convolution blur: registers, output stage, core.
//
//  channel   | signals                               | moves
//  ----------+---------------------------------------+-------------------------------
//  request   | in_valid, in_stall, in_data           | load pixel, load tap, compute
//  result    | out_valid, out_stall, out_data        | one blended pixel per compute
//  config    | psel, penable, pwrite, paddr, pwdata  | register writes and reads
//
// A load request is taken while the core is idle. A compute request keeps in_stall
//   high after acceptance through the bit-serial position divide, the offset back-steps,
//   the one-tap-a-cycle texture store port, the pipeline drain and the divide by the
//   weight sum (38 steps at the default size). The result register loads on the last
//   stalled cycle.
// Synchronous active-high reset clears the registers to their defaults; the stores
//   hold garbage until loaded. A held result on a stalled output does not block
//   loads; the next compute waits only for the output register to free up.
module masked_blend_convolution_blur #(
  parameter int TEX_DIM  = mbcb_pkg::TEX_DIM_DEF,
  parameter int MAX_TAPS = mbcb_pkg::MAX_TAPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbcb_pkg::ADDR_W-1:0]     paddr,
  input  logic [mbcb_pkg::DATA_W-1:0]     pwdata,
  output logic [mbcb_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mbcb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mbcb_pkg::out_item_t             out_data
);

  mbcb_pkg::cfg_t       cfg;
  mbcb_pkg::dp_cmd_t    cmd;
  mbcb_pkg::dp_status_t status;
  mbcb_pkg::out_item_t  result;
  logic                 emit, out_free, cfg_wr;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // register file; values are kept as written, clamping happens in the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode   <= mbcb_pkg::MODE_2D;
      cfg.filter_width  <= 4'd1;
      cfg.filter_height <= 4'd1;
      cfg.weight_sum    <= mbcb_pkg::WS_W'(4096);
      cfg.blend_factor  <= mbcb_pkg::BF_W'(mbcb_pkg::FULL_BLEND);
      cfg.channel_mask  <= mbcb_pkg::ALL_CHANNELS;
      cfg.image_width   <= 7'd64;
      cfg.image_height  <= 7'd64;
    end else if (cfg_wr) begin
      case (reg_idx)
        mbcb_pkg::REG_FILTER_MODE:   cfg.filter_mode   <= pwdata[1:0];
        mbcb_pkg::REG_FILTER_WIDTH:  cfg.filter_width  <= pwdata[3:0];
        mbcb_pkg::REG_FILTER_HEIGHT: cfg.filter_height <= pwdata[3:0];
        mbcb_pkg::REG_WEIGHT_SUM:    cfg.weight_sum    <= pwdata[mbcb_pkg::WS_W-1:0];
        mbcb_pkg::REG_BLEND_FACTOR:  cfg.blend_factor  <= pwdata[mbcb_pkg::BF_W-1:0];
        mbcb_pkg::REG_CHANNEL_MASK:  cfg.channel_mask  <= pwdata[mbcb_pkg::NUM_CHAN-1:0];
        mbcb_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[6:0];
        mbcb_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read back the register picked by the address
  always_comb begin
    case (reg_idx)
      mbcb_pkg::REG_FILTER_MODE:   prdata = mbcb_pkg::DATA_W'(cfg.filter_mode);
      mbcb_pkg::REG_FILTER_WIDTH:  prdata = mbcb_pkg::DATA_W'(cfg.filter_width);
      mbcb_pkg::REG_FILTER_HEIGHT: prdata = mbcb_pkg::DATA_W'(cfg.filter_height);
      mbcb_pkg::REG_WEIGHT_SUM:    prdata = mbcb_pkg::DATA_W'(cfg.weight_sum);
      mbcb_pkg::REG_BLEND_FACTOR:  prdata = mbcb_pkg::DATA_W'(cfg.blend_factor);
      mbcb_pkg::REG_CHANNEL_MASK:  prdata = mbcb_pkg::DATA_W'(cfg.channel_mask);
      mbcb_pkg::REG_IMAGE_WIDTH:   prdata = mbcb_pkg::DATA_W'(cfg.image_width);
      mbcb_pkg::REG_IMAGE_HEIGHT:  prdata = mbcb_pkg::DATA_W'(cfg.image_height);
      default:                     prdata = '0;
    endcase
  end

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= result;
  end

  mbcb_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_free   (out_free),
    .emit       (emit),
    .status     (status),
    .cmd        (cmd)
  );

  mbcb_datapath #(
    .TEX_DIM  (TEX_DIM),
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

FILE: rtl/core/mbcb_ctrl.sv
// Sequencing state machine of the blur: load, position divide, window, divide, blend.
module mbcb_ctrl #(
  parameter int MAX_TAPS = mbcb_pkg::MAX_TAPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  output logic                 in_stall,
  input  logic                 out_free,
  output logic                 emit,
  input  mbcb_pkg::dp_status_t status,
  output mbcb_pkg::dp_cmd_t    cmd
);

  localparam int ACCW = 32 + $clog2(MAX_TAPS * MAX_TAPS);
  localparam int CNTW = $clog2(ACCW);

  mbcb_pkg::ctrl_state_t state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbcb_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      mbcb_pkg::S_IDLE: begin
        cnt_next = '0;
        if (in_valid && in_command == mbcb_pkg::CMD_COMPUTE) state_next = mbcb_pkg::S_DIVX;
      end
      mbcb_pkg::S_DIVX: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(mbcb_pkg::POS_W - 1)) state_next = mbcb_pkg::S_XMID;
      end
      mbcb_pkg::S_XMID: begin
        cnt_next   = '0;
        state_next = mbcb_pkg::S_DIVY;
      end
      mbcb_pkg::S_DIVY: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(mbcb_pkg::POS_W - 1)) state_next = mbcb_pkg::S_YMID;
      end
      mbcb_pkg::S_YMID:   state_next = mbcb_pkg::S_CENTER;
      mbcb_pkg::S_CENTER: state_next = mbcb_pkg::S_OFFS;
      mbcb_pkg::S_OFFS: begin
        if (status.offs_done) state_next = mbcb_pkg::S_TAPS;
      end
      mbcb_pkg::S_TAPS: begin
        if (status.last_tap) state_next = mbcb_pkg::S_DRAIN;
      end
      mbcb_pkg::S_DRAIN: begin
        cnt_next = '0;
        if (!status.pipe_busy) state_next = mbcb_pkg::S_DIV;
      end
      mbcb_pkg::S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(ACCW - 1)) state_next = mbcb_pkg::S_BLEND;
      end
      mbcb_pkg::S_BLEND: state_next = mbcb_pkg::S_FIN;
      mbcb_pkg::S_FIN:   state_next = mbcb_pkg::S_EMIT;
      mbcb_pkg::S_EMIT: begin
        if (out_free) state_next = mbcb_pkg::S_IDLE;
      end
      default: state_next = mbcb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.xy_op = mbcb_pkg::XY_HOLD;
    in_stall = 1'b1;
    emit     = 1'b0;
    case (state)
      mbcb_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.take    = in_valid && in_command == mbcb_pkg::CMD_COMPUTE;
        cmd.wr_tex  = in_valid && in_command == mbcb_pkg::CMD_LOAD_PIX;
        cmd.wr_coef = in_valid && in_command == mbcb_pkg::CMD_LOAD_COEF;
      end
      mbcb_pkg::S_DIVX:   cmd.xy_op = mbcb_pkg::XY_STEP;
      mbcb_pkg::S_XMID:   cmd.xy_op = mbcb_pkg::XY_LOAD_Y;
      mbcb_pkg::S_DIVY:   cmd.xy_op = mbcb_pkg::XY_STEP;
      mbcb_pkg::S_YMID:   cmd.xy_op = mbcb_pkg::XY_FINISH;
      mbcb_pkg::S_CENTER: cmd.issue_center = 1'b1;
      mbcb_pkg::S_OFFS:   cmd.back_step = !status.offs_done;
      mbcb_pkg::S_TAPS:   cmd.issue_tap = 1'b1;
      mbcb_pkg::S_DRAIN:  cmd.div_load = !status.pipe_busy;
      mbcb_pkg::S_DIV:    cmd.div_step = 1'b1;
      mbcb_pkg::S_BLEND:  cmd.blend_mul = 1'b1;
      mbcb_pkg::S_FIN:    cmd.blend_fin = 1'b1;
      mbcb_pkg::S_EMIT:   emit = out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/mbcb_datapath.sv
// Stores, window address walk, multiply-accumulate, divider lanes and blend.
module mbcb_datapath #(
  parameter int TEX_DIM  = mbcb_pkg::TEX_DIM_DEF,
  parameter int MAX_TAPS = mbcb_pkg::MAX_TAPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mbcb_pkg::cfg_t       cfg,
  input  mbcb_pkg::in_item_t   in_data,
  input  mbcb_pkg::dp_cmd_t    cmd,
  output mbcb_pkg::dp_status_t status,
  output mbcb_pkg::out_item_t  result
);

  localparam int NC        = mbcb_pkg::NUM_CHAN;
  localparam int CW        = mbcb_pkg::CHAN_W;
  localparam int PW        = mbcb_pkg::POS_W;
  localparam int WSW       = mbcb_pkg::WS_W;
  localparam int DW        = $clog2(TEX_DIM + 1);
  localparam int XW        = $clog2(TEX_DIM);
  localparam int TEX_DEPTH = TEX_DIM * TEX_DIM;
  localparam int TAW       = $clog2(TEX_DEPTH);
  localparam int COEF_DEPTH = MAX_TAPS * MAX_TAPS;
  localparam int CAW       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int TCW       = $clog2(MAX_TAPS + 1);
  localparam int ACCW      = 32 + $clog2(MAX_TAPS * MAX_TAPS);
  localparam int PRW       = 2 * CW;
  localparam int BPW       = CW + mbcb_pkg::BF_W + 1;

  // effective configuration
  logic [DW-1:0]          img_w, img_h;
  logic [TCW-1:0]         fw_e, fh_e, cols, rows, offx, offy;
  logic [WSW-1:0]         ws_e;
  logic [mbcb_pkg::BF_W-1:0] f_e, inv_f;

  always_comb begin
    img_w = (cfg.image_width == '0) ? DW'(1) :
            ((int'(cfg.image_width) > TEX_DIM) ? DW'(TEX_DIM) : DW'(cfg.image_width));
    img_h = (cfg.image_height == '0) ? DW'(1) :
            ((int'(cfg.image_height) > TEX_DIM) ? DW'(TEX_DIM) : DW'(cfg.image_height));
    fw_e  = (cfg.filter_width == '0) ? TCW'(1) :
            ((int'(cfg.filter_width) > MAX_TAPS) ? TCW'(MAX_TAPS) : TCW'(cfg.filter_width));
    fh_e  = (cfg.filter_height == '0) ? TCW'(1) :
            ((int'(cfg.filter_height) > MAX_TAPS) ? TCW'(MAX_TAPS) : TCW'(cfg.filter_height));
    ws_e  = (cfg.weight_sum == '0) ? WSW'(1) : cfg.weight_sum;
    f_e   = (int'(cfg.blend_factor) > mbcb_pkg::FULL_BLEND) ?
            mbcb_pkg::BF_W'(mbcb_pkg::FULL_BLEND) : cfg.blend_factor;
    inv_f = mbcb_pkg::BF_W'(mbcb_pkg::FULL_BLEND - int'(f_e));
    case (cfg.filter_mode)
      mbcb_pkg::MODE_HORIZ: begin
        cols = fw_e; rows = TCW'(1); offx = fw_e >> 1; offy = '0;
      end
      mbcb_pkg::MODE_VERT: begin
        cols = TCW'(1); rows = fw_e; offx = '0; offy = fw_e >> 1;
      end
      default: begin
        cols = fw_e; rows = fh_e; offx = fw_e >> 1; offy = fh_e >> 1;
      end
    endcase
  end

  // latched compute request
  logic [PW-1:0]         pos_r;
  logic signed [CW-1:0]  old_ch [NC];
  logic signed [CW-1:0]  in_ch  [NC];

  assign in_ch[0] = in_data.chan0;
  assign in_ch[1] = in_data.chan1;
  assign in_ch[2] = in_data.chan2;
  assign in_ch[3] = in_data.chan3;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos_r <= in_data.position;
      for (int c = 0; c < NC; c++) old_ch[c] <= in_ch[c];
    end
  end

  // position to x, y: restoring division one bit a cycle
  logic [PW-1:0] xy_q;
  logic [DW-1:0] xy_rem;
  logic          xy_sel_h;
  logic [DW:0]   xy_sh, xy_dsr;
  logic          xy_ge;
  logic [XW-1:0] x_r;

  assign xy_sh  = {xy_rem, xy_q[PW-1]};
  assign xy_dsr = {1'b0, xy_sel_h ? img_h : img_w};
  assign xy_ge  = xy_sh >= xy_dsr;

  // window walk
  logic [XW-1:0]  sx, sy, row0;
  logic [TCW-1:0] bx, by, tk, tr;
  logic [XW-1:0]  sx_back, sy_back, sx_inc, sy_inc;

  assign sx_back = (sx == '0) ? XW'(img_w - 1'b1) : sx - 1'b1;
  assign sy_back = (sy == '0) ? XW'(img_h - 1'b1) : sy - 1'b1;
  assign sx_inc  = (DW'(sx) + 1'b1 == img_w) ? '0 : sx + 1'b1;
  assign sy_inc  = (DW'(sy) + 1'b1 == img_h) ? '0 : sy + 1'b1;

  assign status.offs_done = (bx == '0) && (by == '0);
  assign status.last_tap  = (tk == cols - 1'b1) && (tr == rows - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      xy_q     <= in_data.position;
      xy_rem   <= '0;
      xy_sel_h <= 1'b0;
    end else begin
      case (cmd.xy_op)
        mbcb_pkg::XY_STEP: begin
          xy_q   <= {xy_q[PW-2:0], xy_ge};
          xy_rem <= DW'(xy_ge ? xy_sh - xy_dsr : xy_sh);
        end
        mbcb_pkg::XY_LOAD_Y: begin
          x_r      <= XW'(xy_rem);
          xy_rem   <= '0;
          xy_sel_h <= 1'b1;
        end
        mbcb_pkg::XY_FINISH: begin
          sx   <= x_r;
          row0 <= x_r;
          sy   <= XW'(xy_rem);
          bx   <= offx;
          by   <= offy;
          tk   <= '0;
          tr   <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.back_step) begin
      if (bx != '0) begin
        sx   <= sx_back;
        row0 <= sx_back;
        bx   <= bx - 1'b1;
      end
      if (by != '0) begin
        sy <= sy_back;
        by <= by - 1'b1;
      end
    end
    if (cmd.issue_tap) begin
      if (tk == cols - 1'b1) begin
        tk <= '0;
        tr <= tr + 1'b1;
        sx <= row0;
        sy <= sy_inc;
      end else begin
        tk <= tk + 1'b1;
        sx <= sx_inc;
      end
    end
  end

  // read pipeline: address, store read, multiply, accumulate
  logic                   va, vb, vc, ca, cb;
  logic [TAW-1:0]         tex_addr_a;
  logic [CAW-1:0]         coef_addr_a, coef_addr;
  logic [mbcb_pkg::PIX_W-1:0] tex_mem [TEX_DEPTH];
  logic signed [CW-1:0]   coef_mem [COEF_DEPTH];
  logic [mbcb_pkg::PIX_W-1:0] pix_b, center;
  logic signed [CW-1:0]   coef_b;
  logic signed [PRW-1:0]  prod [NC];
  logic signed [ACCW-1:0] acc  [NC];

  assign coef_addr = (cfg.filter_mode == mbcb_pkg::MODE_VERT) ? CAW'(tr) :
                     CAW'(int'(tr) * MAX_TAPS + int'(tk));
  assign status.pipe_busy = va || vb || vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= cmd.issue_tap || cmd.issue_center;
      vb <= va;
      vc <= vb && !cb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_tap || cmd.issue_center) begin
      ca          <= cmd.issue_center;
      tex_addr_a  <= TAW'(int'(sy) * int'(img_w) + int'(sx));
      coef_addr_a <= coef_addr;
    end
    cb <= ca;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_tex && int'(in_data.position) < TEX_DEPTH) begin
      tex_mem[TAW'(in_data.position)] <=
        {in_data.chan3, in_data.chan2, in_data.chan1, in_data.chan0};
    end
    pix_b <= tex_mem[tex_addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_coef && int'(in_data.position) < COEF_DEPTH) begin
      coef_mem[CAW'(in_data.position)] <= in_data.coefficient;
    end
    coef_b <= coef_mem[coef_addr_a];
  end

  always_ff @(posedge clk) begin
    if (vb && cb) center <= pix_b;
    for (int c = 0; c < NC; c++) begin
      prod[c] <= $signed(pix_b[c*CW +: CW]) * coef_b;
    end
    for (int c = 0; c < NC; c++) begin
      if (cmd.take) acc[c] <= '0;
      else if (vc) acc[c] <= acc[c] + ACCW'(prod[c]);
    end
  end

  // divider lanes: rounded magnitude over weight sum, one bit a cycle
  logic [ACCW-1:0]      dvd    [NC];
  logic [WSW-1:0]       drem   [NC];
  logic                 dneg   [NC];
  logic [WSW:0]         dsh    [NC];
  logic                 dge    [NC];
  logic [ACCW-1:0]      amag   [NC];
  logic signed [CW-1:0] blur   [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      amag[c] = acc[c][ACCW-1] ? ACCW'(-acc[c]) : ACCW'(acc[c]);
      dsh[c]  = {drem[c], dvd[c][ACCW-1]};
      dge[c]  = dsh[c] >= {1'b0, ws_e};
      if (dneg[c]) begin
        blur[c] = (dvd[c] > ACCW'(32768)) ? -16'sd32768 : CW'(-dvd[c]);
      end else begin
        blur[c] = (dvd[c] > ACCW'(32767)) ? 16'sd32767 : CW'(dvd[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      if (cmd.div_load) begin
        dneg[c] <= acc[c][ACCW-1];
        dvd[c]  <= amag[c] + ACCW'(ws_e >> 1);
        drem[c] <= '0;
      end else if (cmd.div_step) begin
        dvd[c]  <= {dvd[c][ACCW-2:0], dge[c]};
        drem[c] <= WSW'(dge[c] ? dsh[c] - {1'b0, ws_e} : dsh[c]);
      end
    end
  end

  // blend: old*(1-f) + blur*f, rounded over 2^16 and saturated; masked-off channels take the center pixel
  logic signed [BPW-1:0]  p_old  [NC];
  logic signed [BPW-1:0]  p_blur [NC];
  logic signed [BPW:0]    mix    [NC];
  logic [BPW:0]           mmag   [NC];
  logic [BPW:0]           mq     [NC];
  logic signed [CW-1:0]   mixed  [NC];
  logic signed [CW-1:0]   res    [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      mix[c]  = (BPW+1)'(p_old[c]) + (BPW+1)'(p_blur[c]);
      mmag[c] = mix[c][BPW] ? (BPW+1)'(-mix[c]) : (BPW+1)'(mix[c]);
      mq[c]   = (mmag[c] + (BPW+1)'(32768)) >> 16;
      if (mix[c][BPW]) begin
        mixed[c] = (mq[c] > (BPW+1)'(32768)) ? -16'sd32768 : CW'(-mq[c]);
      end else begin
        mixed[c] = (mq[c] > (BPW+1)'(32767)) ? 16'sd32767 : CW'(mq[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      if (cmd.blend_mul) begin
        p_old[c]  <= old_ch[c] * $signed({1'b0, inv_f});
        p_blur[c] <= blur[c] * $signed({1'b0, f_e});
      end
      if (cmd.blend_fin) begin
        res[c] <= cfg.channel_mask[c] ? mixed[c] : $signed(center[c*CW +: CW]);
      end
    end
  end

  assign result.pixel_index = pos_r;
  assign result.out_chan0   = res[0];
  assign result.out_chan1   = res[1];
  assign result.out_chan2   = res[2];
  assign result.out_chan3   = res[3];

endmodule
